// ===== hdl/vector_line_point_generator_defines.svh =====
// Assertion macros shared by the line point generator RTL.
`ifndef VECTOR_LINE_POINT_GENERATOR_DEFINES_SVH
`define VECTOR_LINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VLPG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VLPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vlpg_pkg.sv =====
// Types and constants of the vector line point generator.
`timescale 1ns / 1ps

package vlpg_pkg;

    localparam int REG_BITS = 16;
    localparam int ACC_BITS = 20;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [REG_BITS-1:0]       reg_t;
    typedef logic [ACC_BITS-1:0]       acc_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_EMIT_THRESHOLD_X = 2'd0;
    localparam cfg_index_t REG_EMIT_THRESHOLD_Y = 2'd1;
    localparam cfg_index_t REG_DEFLECTION_RATE  = 2'd2;
    localparam cfg_index_t REG_DIAGONAL_BONUS   = 2'd3;

    // Register values after reset.
    localparam reg_t RST_EMIT_THRESHOLD_X = 16'd4096;
    localparam reg_t RST_EMIT_THRESHOLD_Y = 16'd4096;
    localparam reg_t RST_DEFLECTION_RATE  = 16'd256;
    localparam reg_t RST_DIAGONAL_BONUS   = 16'd106;

    // Request kinds carried in the input tuser.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Control flags of the segment in progress.
    typedef struct packed {
        logic x_is_major;
        logic y_goes_down;
        logic force_last;
        logic busy;
    } seg_flags_t;

endpackage

// ===== hdl/vlpg_step.sv =====
// Next-state and result logic for one load or tick beat of the line stepper.
`timescale 1ns / 1ps

module vlpg_step #(
    parameter int COORD_BITS = 12
) (
    input  logic                    is_tick,
    input  logic [COORD_BITS-1:0]   start_x,
    input  logic [COORD_BITS-1:0]   start_y,
    input  logic [COORD_BITS-1:0]   end_x,
    input  logic [COORD_BITS-1:0]   end_y,
    input  logic                    mark_last_dot,
    input  vlpg_pkg::reg_t          emit_threshold_x,
    input  vlpg_pkg::reg_t          emit_threshold_y,
    input  vlpg_pkg::reg_t          deflection_rate,
    input  vlpg_pkg::reg_t          diagonal_bonus,
    input  logic [COORD_BITS-1:0]   pos_x,
    input  logic [COORD_BITS-1:0]   pos_y,
    input  logic [COORD_BITS-1:0]   major_delta,
    input  logic [COORD_BITS-1:0]   minor_delta,
    input  logic [COORD_BITS-1:0]   step_count,
    input  logic [COORD_BITS:0]     minor_accum,
    input  vlpg_pkg::acc_t          emit_accum,
    input  vlpg_pkg::seg_flags_t    flags,
    output logic [COORD_BITS-1:0]   pos_x_next,
    output logic [COORD_BITS-1:0]   pos_y_next,
    output logic [COORD_BITS-1:0]   major_delta_next,
    output logic [COORD_BITS-1:0]   minor_delta_next,
    output logic [COORD_BITS-1:0]   step_count_next,
    output logic [COORD_BITS:0]     minor_accum_next,
    output vlpg_pkg::acc_t          emit_accum_next,
    output vlpg_pkg::seg_flags_t    flags_next,
    output logic                    point_valid,
    output logic [COORD_BITS-1:0]   point_x,
    output logic [COORD_BITS-1:0]   point_y,
    output logic                    segment_done
);

    localparam int AB = vlpg_pkg::ACC_BITS;
    localparam int RB = vlpg_pkg::REG_BITS;
    localparam logic [AB-1:0] ACC_MAX = {AB{1'b1}};

    function automatic vlpg_pkg::acc_t sat_add(vlpg_pkg::acc_t a, vlpg_pkg::reg_t b);
        logic [AB:0] s;
        s = {1'b0, a} + {{(AB+1-RB){1'b0}}, b};
        return s[AB] ? ACC_MAX : s[AB-1:0];
    endfunction

    // Load path.
    logic                  swap;
    logic [COORD_BITS-1:0] x0, x1, y0, y1, dx, dy;
    logic                  y_down, x_major;

    // Tick path.
    vlpg_pkg::reg_t        thr;
    vlpg_pkg::acc_t        thr_ext, acc_sub, acc_rate, acc_bonus;
    logic                  last, at_thr, emit, minor_step;
    logic [COORD_BITS:0]   macc_sum, major_ext;
    logic [COORD_BITS-1:0] x_stepped, y_stepped;

    always_comb begin
        swap    = start_x >= end_x;
        x0      = swap ? end_x   : start_x;
        x1      = swap ? start_x : end_x;
        y0      = swap ? end_y   : start_y;
        y1      = swap ? start_y : end_y;
        dx      = x1 - x0;
        y_down  = y1 < y0;
        dy      = y_down ? (y0 - y1) : (y1 - y0);
        x_major = dx > dy;
    end

    always_comb begin
        thr       = flags.x_is_major ? emit_threshold_x : emit_threshold_y;
        thr_ext   = {{(AB-RB){1'b0}}, thr};
        major_ext = {1'b0, major_delta};
        last      = ({1'b0, step_count} + 1'b1) == major_ext;
        at_thr    = emit_accum >= thr_ext;
        emit      = at_thr || (last && flags.force_last);

        // A forced dot below threshold empties the accumulator.
        if (!emit) begin
            acc_sub = emit_accum;
        end else if (at_thr) begin
            acc_sub = emit_accum - thr_ext;
        end else begin
            acc_sub = '0;
        end
        acc_rate = sat_add(acc_sub, deflection_rate);

        macc_sum   = minor_accum + {1'b0, minor_delta};
        minor_step = macc_sum >= major_ext;
        acc_bonus  = minor_step ? sat_add(acc_rate, diagonal_bonus) : acc_rate;

        // Each coordinate moves at most once: on its major step or its minor step.
        x_stepped = (flags.x_is_major || minor_step) ? pos_x + 1'b1 : pos_x;
        if (!flags.x_is_major || minor_step) begin
            y_stepped = flags.y_goes_down ? pos_y - 1'b1 : pos_y + 1'b1;
        end else begin
            y_stepped = pos_y;
        end
    end

    always_comb begin
        pos_x_next       = pos_x;
        pos_y_next       = pos_y;
        major_delta_next = major_delta;
        minor_delta_next = minor_delta;
        step_count_next  = step_count;
        minor_accum_next = minor_accum;
        emit_accum_next  = emit_accum;
        flags_next       = flags;
        point_valid      = 1'b0;
        point_x          = '0;
        point_y          = '0;
        segment_done     = 1'b1;

        if (!is_tick) begin
            pos_x_next             = x0;
            pos_y_next             = y0;
            major_delta_next       = x_major ? dx : dy;
            minor_delta_next       = x_major ? dy : dx;
            step_count_next        = '0;
            minor_accum_next       = '0;
            emit_accum_next        = {{(AB-RB){1'b0}},
                                      x_major ? emit_threshold_x : emit_threshold_y};
            flags_next.x_is_major  = x_major;
            flags_next.y_goes_down = y_down;
            flags_next.force_last  = mark_last_dot;
            flags_next.busy        = x_major ? (dx != '0) : (dy != '0);
        end else if (flags.busy) begin
            point_valid      = emit;
            point_x          = emit ? pos_x : '0;
            point_y          = emit ? pos_y : '0;
            segment_done     = last;
            pos_x_next       = x_stepped;
            pos_y_next       = y_stepped;
            step_count_next  = step_count + 1'b1;
            minor_accum_next = minor_step ? macc_sum - major_ext : macc_sum;
            emit_accum_next  = acc_bonus;
            flags_next.busy  = !last;
        end
    end

endmodule

// ===== hdl/vector_line_point_generator.sv =====
// Top level of the vector line point generator: stream ports, registers, result stage.
`timescale 1ns / 1ps
// Usage
// The input stream carries one request per beat. tuser selects the request:
// a load beat (tuser 0) starts a new segment from its two endpoints and its
// last-dot flag and returns nothing; a tick beat (tuser 1) takes one major
// axis step of the current segment and returns exactly one result beat.
// A load replaces any segment in progress. A tick with no segment loaded
// returns a beat with no point and tlast high.
// Each result beat carries the point coordinates in tdata (zero when no
// point is emitted), the point-valid flag in tuser and the end-of-segment
// marker in tlast.
// Throughput is one input beat per clock unless the receiver stalls. A tick's
// result appears in the output register in the cycle after the tick is accepted.
// The whole step is done between the segment state registers and the output register.
// When the receiver stalls, the pending result stays in the output register
// and the input side stops taking beats until the result is taken; a result
// taken in the same cycle frees the register for the next tick.
// The configuration port writes one register per clock with no wait; write
// it only while no tick result is outstanding.
// Synchronous active-low reset restores the register defaults, empties the
// output register and leaves no segment loaded.

`include "vector_line_point_generator_defines.svh"

module vector_line_point_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // From bit 0: start_x, start_y, end_x, end_y, mark_last_dot, zero fill.
    input  logic [((4 * COORD_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type.
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // From bit 0: point_x, point_y, zero fill.
    output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0]     m_tdata,
    // point_valid.
    output logic                       m_tuser,
    output logic                       m_tlast,
    input  logic                       cfg_wr_en,
    input  vlpg_pkg::cfg_index_t       cfg_index,
    input  vlpg_pkg::reg_t             cfg_data
);

    localparam int M_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int CB = COORD_BITS;

    // Configuration registers.
    vlpg_pkg::reg_t thr_x_reg, thr_y_reg, rate_reg, bonus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_x_reg <= vlpg_pkg::RST_EMIT_THRESHOLD_X;
            thr_y_reg <= vlpg_pkg::RST_EMIT_THRESHOLD_Y;
            rate_reg  <= vlpg_pkg::RST_DEFLECTION_RATE;
            bonus_reg <= vlpg_pkg::RST_DIAGONAL_BONUS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vlpg_pkg::REG_EMIT_THRESHOLD_X: thr_x_reg <= cfg_data;
                vlpg_pkg::REG_EMIT_THRESHOLD_Y: thr_y_reg <= cfg_data;
                vlpg_pkg::REG_DEFLECTION_RATE:  rate_reg  <= cfg_data;
                vlpg_pkg::REG_DIAGONAL_BONUS:   bonus_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Segment state.
    logic [CB-1:0]        pos_x_reg, pos_y_reg, major_delta_reg, minor_delta_reg;
    logic [CB-1:0]        step_count_reg;
    logic [CB:0]          minor_accum_reg;
    vlpg_pkg::acc_t       emit_accum_reg;
    vlpg_pkg::seg_flags_t flags_reg;

    logic [CB-1:0]        pos_x_next, pos_y_next, major_delta_next, minor_delta_next;
    logic [CB-1:0]        step_count_next;
    logic [CB:0]          minor_accum_next;
    vlpg_pkg::acc_t       emit_accum_next;
    vlpg_pkg::seg_flags_t flags_next;

    // Result stage.
    logic          m_tvalid_reg, point_valid_reg, segment_done_reg;
    logic [CB-1:0] point_x_reg, point_y_reg;
    logic          point_valid_next, segment_done_next;
    logic [CB-1:0] point_x_next, point_y_next;

    logic s_accept, is_tick;

    // The output register accepts a new result whenever it is empty or drains now.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign is_tick  = s_tuser == vlpg_pkg::REQ_TICK;

    vlpg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .is_tick          (is_tick),
        .start_x          (s_tdata[CB-1:0]),
        .start_y          (s_tdata[2*CB-1:CB]),
        .end_x            (s_tdata[3*CB-1:2*CB]),
        .end_y            (s_tdata[4*CB-1:3*CB]),
        .mark_last_dot    (s_tdata[4*CB]),
        .emit_threshold_x (thr_x_reg),
        .emit_threshold_y (thr_y_reg),
        .deflection_rate  (rate_reg),
        .diagonal_bonus   (bonus_reg),
        .pos_x            (pos_x_reg),
        .pos_y            (pos_y_reg),
        .major_delta      (major_delta_reg),
        .minor_delta      (minor_delta_reg),
        .step_count       (step_count_reg),
        .minor_accum      (minor_accum_reg),
        .emit_accum       (emit_accum_reg),
        .flags            (flags_reg),
        .pos_x_next       (pos_x_next),
        .pos_y_next       (pos_y_next),
        .major_delta_next (major_delta_next),
        .minor_delta_next (minor_delta_next),
        .step_count_next  (step_count_next),
        .minor_accum_next (minor_accum_next),
        .emit_accum_next  (emit_accum_next),
        .flags_next       (flags_next),
        .point_valid      (point_valid_next),
        .point_x          (point_x_next),
        .point_y          (point_y_next),
        .segment_done     (segment_done_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            step_count_reg  <= '0;
            minor_accum_reg <= '0;
            emit_accum_reg  <= '0;
            flags_reg       <= '0;
        end else if (s_accept) begin
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            step_count_reg  <= step_count_next;
            minor_accum_reg <= minor_accum_next;
            emit_accum_reg  <= emit_accum_next;
            flags_reg       <= flags_next;
        end
    end

    // Only a tick beat produces a result; a load beat simply lets the register drain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept && is_tick) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_tick) begin
            point_valid_reg  <= point_valid_next;
            point_x_reg      <= point_x_next;
            point_y_reg      <= point_y_next;
            segment_done_reg <= segment_done_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({point_y_reg, point_x_reg});
    assign m_tuser  = point_valid_reg;
    assign m_tlast  = segment_done_reg;

    // A tick with no segment loaded yields an empty, segment-done result next cycle.
    `VLPG_ASSERT_NEXT(a_idle_tick_result, aclk, aresetn,
        s_accept && is_tick && !flags_reg.busy,
        m_tvalid && m_tlast && !m_tuser, "idle tick did not give an empty done beat")
    // While a segment runs, the step counter stays below the major extent.
    `VLPG_ASSERT_NOW(a_step_in_range, aclk, aresetn,
        flags_reg.busy, step_count_reg < major_delta_reg, "step counter ran past segment end")
    // The Bresenham error term stays below the major extent.
    `VLPG_ASSERT_NOW(a_minor_accum_bound, aclk, aresetn,
        flags_reg.busy, (minor_accum_reg < {1'b0, major_delta_reg}),
        "minor accumulator out of range")
    // The final step of a segment leaves the stepper idle.
    `VLPG_ASSERT_NEXT(a_last_step_idles, aclk, aresetn,
        s_accept && is_tick && flags_reg.busy && segment_done_next,
        !flags_reg.busy, "stepper still busy after final step")

endmodule
